@@ hdl/pq_lookup_table_distance_scan_macros.svh @@
// Assertion macros for the lookup-table distance scan.
`ifndef PQ_LOOKUP_TABLE_DISTANCE_SCAN_MACROS_SVH
`define PQ_LOOKUP_TABLE_DISTANCE_SCAN_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PQS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define PQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hdl/pqs_pkg.sv @@
// Package with types and constants of the lookup-table distance scan.
package pqs_pkg;
    localparam int VALUE_W = 16;
    localparam int LUT_W   = 40;
    localparam int ACC_W   = 48;
    localparam logic signed [ACC_W-1:0] ONE_Q28 = 48'sd268435456;

    typedef enum logic [1:0] {
        OP_CB_WRITE = 2'd0,
        OP_QUERY    = 2'd1,
        OP_CODE     = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        CFG_METRIC = 1'b0,
        CFG_SUBS   = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SWEEP = 2'd1,
        ST_CODE  = 2'd2,
        ST_OUT   = 2'd3
    } state_t;

    function automatic logic signed [LUT_W-1:0] sat_lut(input logic signed [LUT_W+1:0] x);
        logic signed [LUT_W+1:0] hi;
        logic signed [LUT_W+1:0] lo;
        hi = {3'b000, {(LUT_W-1){1'b1}}};
        lo = ~hi;
        if (x > hi) begin
            return hi[LUT_W-1:0];
        end else if (x < lo) begin
            return lo[LUT_W-1:0];
        end
        return x[LUT_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] x);
        logic signed [ACC_W:0] hi;
        logic signed [ACC_W:0] lo;
        hi = {2'b00, {(ACC_W-1){1'b1}}};
        lo = ~hi;
        if (x > hi) begin
            return hi[ACC_W-1:0];
        end else if (x < lo) begin
            return lo[ACC_W-1:0];
        end
        return x[ACC_W-1:0];
    endfunction
endpackage

@@ hdl/pqs_lut_sweep.sv @@
// Table-building pipeline: codebook read, term multiply, table read-modify-write.
module pqs_lut_sweep import pqs_pkg::*; #(
    parameter int PQ_DIM_MAX  = 16,
    parameter int CENTROIDS   = 256,
    parameter int SUB_DIM_MAX = 8,
    localparam int SUB_W = (PQ_DIM_MAX > 1) ? $clog2(PQ_DIM_MAX) : 1,
    localparam int CEN_W = (CENTROIDS > 1) ? $clog2(CENTROIDS) : 1,
    localparam int DIM_W = (SUB_DIM_MAX > 1) ? $clog2(SUB_DIM_MAX) : 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cb_we,
    input  logic [SUB_W-1:0]         cb_sub,
    input  logic [CEN_W-1:0]         cb_cen,
    input  logic [DIM_W-1:0]         cb_dim,
    input  logic signed [VALUE_W-1:0] cb_value,
    input  logic                     sw_start,
    input  logic [SUB_W-1:0]         sw_sub,
    input  logic [DIM_W-1:0]         sw_dim,
    input  logic signed [VALUE_W-1:0] sw_value,
    input  logic                     sw_metric,
    output logic                     sw_busy,
    input  logic                     lk_re,
    input  logic [SUB_W-1:0]         lk_sub,
    input  logic [CEN_W-1:0]         lk_cen,
    output logic signed [LUT_W-1:0]  lk_data
);
    localparam int CB_DEPTH  = PQ_DIM_MAX * CENTROIDS * SUB_DIM_MAX;
    localparam int LUT_DEPTH = PQ_DIM_MAX * CENTROIDS;
    localparam int CNT_W     = $clog2(CENTROIDS + 1);

    logic signed [VALUE_W-1:0] cb_mem [CB_DEPTH];
    logic signed [LUT_W-1:0]   lut_mem [LUT_DEPTH];

    logic                  run_reg, run_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SUB_W-1:0]      sub_reg;
    logic [DIM_W-1:0]      dim_reg;
    logic signed [VALUE_W-1:0] q_reg;
    logic                  met_reg;

    // Stage 1: codebook and table read issued.
    logic                  s1_v_reg;
    logic [CEN_W-1:0]      s1_cen_reg;
    logic signed [VALUE_W-1:0] cb_rd_reg;
    logic signed [LUT_W-1:0]   lut_rd_reg;
    // Stage 2: term registered.
    logic                  s2_v_reg;
    logic [CEN_W-1:0]      s2_cen_reg;
    logic signed [33:0]    term_reg;
    logic signed [LUT_W-1:0] old_reg;

    logic signed [VALUE_W:0]   diff;
    logic signed [33:0]        term_next;
    logic signed [LUT_W+1:0]   sum_w;
    logic signed [LUT_W-1:0]   new_entry;
    logic [CEN_W-1:0]          rd_cen;

    assign rd_cen = cnt_reg[CEN_W-1:0];

    always_comb begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        if (sw_start) begin
            run_next = 1'b1;
            cnt_next = '0;
        end else if (run_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CENTROIDS - 1)) begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            s1_v_reg <= run_reg;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (sw_start) begin
            sub_reg <= sw_sub;
            dim_reg <= sw_dim;
            q_reg   <= sw_value;
            met_reg <= sw_metric;
        end
    end

    // Codebook memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cb_we) begin
            cb_mem[{cb_sub, cb_cen, cb_dim}] <= cb_value;
        end
        cb_rd_reg <= cb_mem[{sub_reg, rd_cen, dim_reg}];
    end

    // Each centroid entry is touched once per sweep, so writes never overlap reads.
    always_ff @(posedge aclk) begin
        if (s2_v_reg) begin
            lut_mem[{sub_reg, s2_cen_reg}] <= new_entry;
        end
        lut_rd_reg <= lut_mem[{sub_reg, rd_cen}];
        if (lk_re) begin
            lk_data <= lut_mem[{lk_sub, lk_cen}];
        end
        s1_cen_reg <= rd_cen;
        s2_cen_reg <= s1_cen_reg;
        old_reg    <= lut_rd_reg;
        term_reg   <= term_next;
    end

    always_comb begin
        diff = '0;
        if (met_reg) begin
            term_next = 34'(q_reg * cb_rd_reg);
        end else begin
            diff      = (VALUE_W+1)'(q_reg) - (VALUE_W+1)'(cb_rd_reg);
            term_next = 34'(diff * diff);
        end
        if (dim_reg == '0) begin
            sum_w = (LUT_W+2)'(term_reg);
        end else begin
            sum_w = (LUT_W+2)'(old_reg) + (LUT_W+2)'(term_reg);
        end
        new_entry = sat_lut(sum_w);
    end

    assign sw_busy = run_reg | s1_v_reg | s2_v_reg;
endmodule

@@ hdl/pq_lookup_table_distance_scan.sv @@
// Top level of the product-quantization lookup-table distance scan.
// The block holds a codebook memory and a distance table memory. A query element sweeps all
// CENTROIDS table entries of its subspace through a three-stage read, multiply and write-back
// pipeline, so it keeps the block busy until the last entry is written back through the single
// table write port. A code byte reads one table entry through a registered read port and adds
// it to the accumulator in ST_CODE; the byte of the last subspace in use then moves the distance
// through the accumulator and ST_OUT into an output register that holds until taken. While that
// result waits the block keeps accepting transactions; only a second finished distance has to
// wait in the accumulator, stalling the input, until the first is taken. No reset clearing pass
// is needed: both memories are undefined until written.
module pq_lookup_table_distance_scan import pqs_pkg::*; #(
    parameter int PQ_DIM_MAX  = 16,
    parameter int CENTROIDS   = 256,
    parameter int SUB_DIM_MAX = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [3:0]         s_sub_index,
    input  logic [7:0]         s_centroid,
    input  logic [2:0]         s_dim_index,
    input  logic signed [15:0] s_value,
    input  logic [7:0]         s_code,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_distance
);
`include "pq_lookup_table_distance_scan_macros.svh"
    localparam int SUB_W = (PQ_DIM_MAX > 1) ? $clog2(PQ_DIM_MAX) : 1;
    localparam int CEN_W = (CENTROIDS > 1) ? $clog2(CENTROIDS) : 1;
    localparam int DIM_W = (SUB_DIM_MAX > 1) ? $clog2(SUB_DIM_MAX) : 1;

    state_t state_reg, state_next;
    logic                metric_reg;
    logic [4:0]          subs_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] out_reg, out_next;
    logic                mv_reg, mv_next;
    logic                last_reg, last_next;
    logic                hit_reg, hit_next;

    logic                accept;
    logic                idx_ok;
    logic [4:0]          n_act;
    logic                sw_start, sw_busy, cb_we;
    logic signed [LUT_W-1:0] lk_data;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_new;
    logic signed [ACC_W:0]   ip_res;
    op_t                 op;

    assign op        = op_t'(s_op);
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && !sw_busy;
    assign accept    = s_valid && s_ready;
    assign m_valid   = mv_reg;
    assign m_distance = out_reg;

    // Subspace count clamped into 1..PQ_DIM_MAX.
    always_comb begin
        n_act = subs_reg;
        if (n_act == 5'd0) begin
            n_act = 5'd1;
        end else if (32'(n_act) > PQ_DIM_MAX) begin
            n_act = 5'(PQ_DIM_MAX);
        end
    end

    assign idx_ok = (32'(s_sub_index) < PQ_DIM_MAX);
    assign cb_we  = accept && (op == OP_CB_WRITE) && idx_ok && (32'(s_centroid) < CENTROIDS)
                    && (32'(s_dim_index) < SUB_DIM_MAX);
    assign sw_start = accept && (op == OP_QUERY) && idx_ok && (32'(s_dim_index) < SUB_DIM_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            metric_reg <= 1'b0;
            subs_reg   <= 5'd16;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_METRIC: metric_reg <= cfg_data[0];
                CFG_SUBS:   subs_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    pqs_lut_sweep #(
        .PQ_DIM_MAX (PQ_DIM_MAX),
        .CENTROIDS  (CENTROIDS),
        .SUB_DIM_MAX(SUB_DIM_MAX)
    ) u_sweep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cb_we    (cb_we),
        .cb_sub   (s_sub_index[SUB_W-1:0]),
        .cb_cen   (s_centroid[CEN_W-1:0]),
        .cb_dim   (s_dim_index[DIM_W-1:0]),
        .cb_value (s_value),
        .sw_start (sw_start),
        .sw_sub   (s_sub_index[SUB_W-1:0]),
        .sw_dim   (s_dim_index[DIM_W-1:0]),
        .sw_value (s_value),
        .sw_metric(metric_reg),
        .sw_busy  (sw_busy),
        .lk_re    (accept),
        .lk_sub   (s_sub_index[SUB_W-1:0]),
        .lk_cen   (s_code[CEN_W-1:0]),
        .lk_data  (lk_data)
    );

    // The table read for a code byte issues on the accept edge; ST_CODE sees the data.
    always_comb begin
        acc_sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(lk_data);
        acc_new = hit_reg ? sat_acc(acc_sum) : acc_reg;
        ip_res  = (ACC_W+1)'(ONE_Q28) - (ACC_W+1)'(acc_new);
    end

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        out_next   = out_reg;
        mv_next    = mv_reg;
        last_next  = last_reg;
        hit_next   = hit_reg;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (op == OP_CODE) && idx_ok && ({1'b0, s_sub_index} < n_act)) begin
                    hit_next   = (32'(s_code) < CENTROIDS);
                    last_next  = ({1'b0, s_sub_index} == n_act - 5'd1);
                    state_next = ST_CODE;
                end
            end
            ST_CODE: begin
                if (last_reg) begin
                    // The finished distance is parked in the accumulator until ST_OUT hands it over.
                    acc_next   = metric_reg ? sat_acc(ip_res) : acc_new;
                    state_next = ST_OUT;
                end else begin
                    acc_next   = acc_new;
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                // Hand the distance over once the output register is free or being taken.
                if (!mv_reg || m_ready) begin
                    out_next   = acc_reg;
                    acc_next   = '0;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            acc_reg   <= '0;
            mv_reg    <= 1'b0;
            last_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            mv_reg    <= mv_next;
            last_reg  <= last_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    // A waiting result stays valid with its distance unchanged.
    `PQS_ASSERT_NEXT(a_no_overwrite, mv_reg && !m_ready, mv_reg && (m_distance == $past(m_distance)), "result changed while waiting")
    // No transaction is taken while a table sweep runs.
    `PQS_ASSERT_IMP(a_sweep_block, sw_busy, !s_ready, "input taken during sweep")
    // The accumulator is clear after a result is handed over.
    `PQS_ASSERT_NEXT(a_acc_clear, state_reg == ST_OUT && (!mv_reg || m_ready), acc_reg == '0, "accumulator not cleared")
endmodule

@@ tb/tb_pq_lookup_table_distance_scan.sv @@
// Self-checking testbench for the lookup-table product-quantization distance scan.
module tb_pq_lookup_table_distance_scan;
    timeunit 1ns;
    timeprecision 1ps;

    import pqs_pkg::*;

    // Saturation bounds of the table entries and of the distance accumulator.
    localparam longint TABLE_MAX = (64'sd1 <<< 39) - 1;
    localparam longint SUM_MAX   = (64'sd1 <<< 47) - 1;
    localparam longint ONE_FIX   = 64'sd1 <<< 28;
    // A query element keeps the block busy for a whole table sweep without a result, so
    // wait_drained lets DRAIN_CYCLES pass before any register write or the end of the run.
    localparam int     DRAIN_CYCLES = 300;

    typedef struct packed {
        op_t               op;
        logic [3:0]        sub;
        logic [7:0]        cen;
        logic [2:0]        dim;
        logic signed [15:0] val;
        logic [7:0]        code;
    } scan_item_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = CFG_METRIC;
    logic [4:0]         cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_op = OP_NONE;
    logic [3:0]         s_sub_index = '0;
    logic [7:0]         s_centroid = '0;
    logic [2:0]         s_dim_index = '0;
    logic signed [15:0] s_value = '0;
    logic [7:0]         s_code = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [47:0] m_distance;

    pq_lookup_table_distance_scan uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_sub_index (s_sub_index),
        .s_centroid  (s_centroid),
        .s_dim_index (s_dim_index),
        .s_value     (s_value),
        .s_code      (s_code),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_distance  (m_distance)
    );

    always #6 aclk = ~aclk;

    // Shadow copy of the block's state, updated as transactions are accepted.
    logic signed [15:0] shadow_codebook [0:32767];
    longint             shadow_table [0:4095];
    longint             shadow_sum = 0;
    logic               shadow_metric = 1'b0;
    logic [4:0]         shadow_subs = 5'd16;

    scan_item_t   pending_items [$];
    longint       dist_expect_q [$];
    int           mismatch_count = 0;
    bit           calm = 1'b0;

    // Columns of the codebook (subspace, dimension) that are fully loaded before any query
    // reads them. Every subspace listed here gets a dimension-zero query during setup, so
    // its table row is valid from then on.
    int           col_sub [4] = '{0, 1, 15, 0};
    int           col_dim [4] = '{0, 0, 0, 7};
    int           gen_subs = 16;

    function automatic longint clamp_to(input longint x, input longint hi);
        if (x > hi) return hi;
        if (x < -hi - 1) return -hi - 1;
        return x;
    endfunction

    function automatic int active_count(input logic [4:0] raw);
        if (raw == 0) return 1;
        if (raw > 16) return 16;
        return raw;
    endfunction

    // Applies one accepted transaction to the shadow state and queues the distance it emits.
    task automatic predict_scan(input scan_item_t it);
        longint c;
        longint term;
        longint v;
        int     n;
        int     row;
        v = it.val;
        case (it.op)
            OP_CB_WRITE: begin
                shadow_codebook[{it.sub, it.cen, it.dim}] = it.val;
            end
            OP_QUERY: begin
                for (int j = 0; j < 256; j++) begin
                    row = {it.sub, j[7:0]};
                    c = shadow_codebook[{it.sub, j[7:0], it.dim}];
                    term = shadow_metric ? v * c : (v - c) * (v - c);
                    if (it.dim == 0) shadow_table[row] = clamp_to(term, TABLE_MAX);
                    else shadow_table[row] = clamp_to(shadow_table[row] + term, TABLE_MAX);
                end
            end
            OP_CODE: begin
                n = active_count(shadow_subs);
                if (it.sub < n) begin
                    shadow_sum = clamp_to(shadow_sum + shadow_table[{it.sub, it.code}], SUM_MAX);
                    if (it.sub == n - 1) begin
                        dist_expect_q.push_back(shadow_metric ?
                            clamp_to(ONE_FIX - shadow_sum, SUM_MAX) : shadow_sum);
                        shadow_sum = 0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Input driver. Items come from pending_items; idle bursts are inserted between
    // transactions but never while an item is waiting to be accepted.
    int src_gap = 0;
    always @(posedge aclk) begin
        scan_item_t it;
        bit         taken;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            taken = s_valid && s_ready;
            if (taken) begin
                it.op   = op_t'(s_op);
                it.sub  = s_sub_index;
                it.cen  = s_centroid;
                it.dim  = s_dim_index;
                it.val  = s_value;
                it.code = s_code;
                predict_scan(it);
            end
            if (!s_valid || taken) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(1, 13) - 1;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    s_op        <= it.op;
                    s_sub_index <= it.sub;
                    s_centroid  <= it.cen;
                    s_dim_index <= it.dim;
                    s_value     <= it.val;
                    s_code      <= it.code;
                    s_valid     <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: random back-pressure bursts, then a field check against the oldest
    // expected distance.
    int sink_gap = 0;
    always @(posedge aclk) begin
        longint want;
        if (aresetn && m_valid && m_ready) begin
            if (dist_expect_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result transaction: distance %0d", m_distance);
            end else begin
                want = dist_expect_q.pop_front();
                if (m_distance !== want[47:0]) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Distance mismatch: expected %0d, got %0d", want, m_distance);
                end
            end
        end
        if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            sink_gap = $urandom_range(1, 13) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic add_item(input op_t op, input int sub, input int cen, input int dim,
                            input int val, input int code);
        scan_item_t it;
        it.op   = op;
        it.sub  = 4'(sub);
        it.cen  = 8'(cen);
        it.dim  = 3'(dim);
        it.val  = 16'(val);
        it.code = 8'(code);
        pending_items.push_back(it);
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // Blocks until the block has no work left: all items taken, all distances returned,
    // and enough cycles passed for a query sweep to finish.
    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || dist_expect_q.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [4:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_METRIC) shadow_metric = data[0];
        else shadow_subs = data;
    endtask

    // One code vector: a byte for every loaded subspace in use, in shuffled order, with
    // the byte of the last subspace closing it. Now and then that byte is left out, so the
    // partial sum carries into the next vector.
    task automatic add_vector();
        int subs [$];
        int k;
        int tmp;
        foreach (col_sub[i])
            if (col_dim[i] == 0 && col_sub[i] < gen_subs - 1) subs.push_back(col_sub[i]);
        for (int i = subs.size() - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            tmp = subs[i];
            subs[i] = subs[k];
            subs[k] = tmp;
        end
        if ($urandom_range(0, 9) != 0) subs.push_back(gen_subs - 1);
        foreach (subs[i]) add_item(OP_CODE, subs[i], $urandom(), $urandom(), $urandom(),
                                   $urandom_range(0, 255));
    endtask

    task automatic run_phase(input logic metric, input logic [4:0] subs, input int count);
        int r;
        int c;
        wait_drained();
        write_reg(CFG_METRIC, {4'b0, metric});
        write_reg(CFG_SUBS, subs);
        gen_subs = active_count(subs);
        while (count > 0) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                add_vector();
            end else if (r < 70) begin
                c = $urandom_range(0, 3);
                add_item(OP_QUERY, col_sub[c], $urandom(), col_dim[c], pick_value(),
                         $urandom());
            end else if (r < 82) begin
                add_item(OP_CB_WRITE, $urandom(), $urandom(), $urandom(), pick_value(),
                         $urandom());
            end else if (r < 92 && gen_subs < 16) begin
                // A code byte past the subspaces in use is dropped by the block.
                add_item(OP_CODE, $urandom_range(gen_subs, 15), $urandom(), $urandom(),
                         $urandom(), $urandom());
            end else begin
                add_item(OP_NONE, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            end
            count--;
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Load the chosen codebook columns; centroid 0 and 255 carry the most negative and
        // most positive element.
        foreach (col_sub[i])
            for (int j = 0; j < 256; j++)
                add_item(OP_CB_WRITE, col_sub[i], j, col_dim[i],
                         j == 0 ? 16'sh8000 : (j == 255 ? 16'sh7FFF : pick_value()),
                         $urandom());

        // Directed part: dimension-zero queries, mostly with extreme elements, build each table row,
        // an accumulating query follows, then an unused op and code bytes, the first a maximal code.
        add_item(OP_QUERY, 0, 0, 0, 16'sh7FFF, 0);
        add_item(OP_QUERY, 1, 0, 0, 16'sh8000, 0);
        add_item(OP_QUERY, 15, 0, 0, 16'sh4000, 0);
        add_item(OP_QUERY, 0, 0, 7, 16'sh8000, 0);
        add_item(OP_NONE, 15, 255, 7, 16'shFFFF, 255);
        add_item(OP_CODE, 0, 0, 0, 0, 255);
        add_item(OP_CODE, 15, 0, 0, 0, 0);
        add_item(OP_CODE, 1, 0, 0, 0, 0);

        run_phase(1'b0, 5'd16, 40);
        run_phase(1'b1, 5'd16, 40);
        run_phase(1'b0, 5'd1, 30);
        run_phase(1'b1, 5'd2, 30);
        run_phase(1'b0, 5'd2, 30);
        run_phase(1'b1, 5'd0, 30);
        run_phase(1'b0, 5'd31, 30);
        run_phase(1'b1, 5'd1, 30);
        wait_drained();
        calm = 1'b1;
        run_phase(1'b1, 5'd16, 50);
        wait_drained();

        if (mismatch_count == 0 && dist_expect_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog against a stalled handshake.
    initial begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

@@ pq_lookup_table_distance_scan.f @@
+incdir+hdl
hdl/pqs_pkg.sv
hdl/pqs_lut_sweep.sv
hdl/pq_lookup_table_distance_scan.sv
tb/tb_pq_lookup_table_distance_scan.sv
